### rtl/core/paz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package paz_pkg;

  // Fixed pipeline depths of the unit vector path
  localparam int SQRT_STEPS = 32;
  localparam int QUOT_BITS  = 29;
  localparam int UNIT_LAT   = 5 + SQRT_STEPS + QUOT_BITS + 1;

  localparam int UNIT_W = 30;
  localparam int POL_W  = 18;
  localparam int PHI_W  = 16;

  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [POL_W-1:0]  pol_t;
  typedef logic signed [PHI_W-1:0]  phi_t;

  // Angle constants, radians in Q30 unless noted; PHI_LIMIT is in Q13
  localparam logic signed [31:0] DEG_TO_RAD_Q36 = 32'sd1199154869;
  localparam logic [30:0]        HALF_PI_Q30    = 31'd1686629713;
  localparam logic [35:0]        ANGLE_OFFSET   = 36'd27829390264;
  localparam logic signed [33:0] HALF_PI_S      = 34'sd1686629713;
  localparam logic signed [33:0] QUARTER_PI_S   = 34'sd843314856;
  localparam logic signed [33:0] GAIN_Q28       = 34'sd163008219;
  localparam logic signed [15:0] PHI_LIMIT      = 16'sd25736;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Position of the leading one plus one; zero for zero
  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // Bring a value with the given bit length to bit length 30
  function automatic logic signed [63:0] scale_to30(input logic signed [63:0] v,
                                                    input logic [6:0] len);
    logic signed [63:0] r;
    if (len > 7'd30) begin
      r = (v + (64'sd1 <<< (len - 7'd31))) >>> (len - 7'd30);
    end else begin
      r = v <<< (7'd30 - len);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/paz_unit3.sv
`timescale 1ns / 1ps
`default_nettype none

module paz_unit3 #(
  parameter int MOMENTUM_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_v [3],
  output logic                             out_valid,
  output logic                             out_ok,
  output paz_pkg::unit_t                   out_u [3]
);
  import paz_pkg::*;

  localparam int MW = MOMENTUM_WIDTH;

  typedef struct packed {
    logic [62:0]      rem;
    logic [62:0]      res;
    logic [2:0][31:0] s;
    logic             zero;
  } sq_t;

  typedef struct packed {
    logic [2:0][60:0] rem;
    logic [2:0][28:0] q;
    logic [2:0]       neg;
    logic [31:0]      n;
    logic             zero;
  } dv_t;

  logic                 u1_vld_r, u2_vld_r, u3_vld_r, u4_vld_r;
  logic [SQRT_STEPS:0]  sq_vld_r;
  logic [QUOT_BITS:1]   dv_vld_r;
  logic                 out_vld_r;

  logic [MW-1:0]        mag_c [3];
  logic [MW-1:0]        max_c;
  logic signed [MW-1:0] u1_v_r [3];
  logic [MW-1:0]        u1_max_r;
  logic signed [MW-1:0] u2_v_r [3];
  logic [5:0]           u2_len_r;
  logic                 u2_zero_r;
  logic signed [31:0]   u3_s_r [3];
  logic                 u3_zero_r;
  logic signed [31:0]   u4_s_r [3];
  logic [60:0]          u4_sq_r [3];
  logic                 u4_zero_r;
  logic signed [63:0]   sq_full_c [3];
  logic [61:0]          sum_c;

  sq_t   sq_r [SQRT_STEPS+1];
  dv_t   dv0_c;
  dv_t   dv_r [1:QUOT_BITS];
  unit_t out_u_r [3];
  logic  out_ok_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_vld_r  <= 1'b0;
      u2_vld_r  <= 1'b0;
      u3_vld_r  <= 1'b0;
      u4_vld_r  <= 1'b0;
      sq_vld_r  <= '0;
      dv_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      u1_vld_r  <= in_valid;
      u2_vld_r  <= u1_vld_r;
      u3_vld_r  <= u2_vld_r;
      u4_vld_r  <= u3_vld_r;
      sq_vld_r  <= {sq_vld_r[SQRT_STEPS-1:0], u4_vld_r};
      dv_vld_r  <= {dv_vld_r[QUOT_BITS-1:1], sq_vld_r[SQRT_STEPS]};
      out_vld_r <= dv_vld_r[QUOT_BITS];
    end
  end

  // Find the largest component magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_v[i][MW-1] ? (~in_v[i] + 1'b1) : in_v[i];
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    u1_v_r   <= in_v;
    u1_max_r <= max_c;
  end

  // Measure its bit length
  always_ff @(posedge clk) begin
    u2_v_r    <= u1_v_r;
    u2_len_r  <= 6'(bit_len(64'(u1_max_r)));
    u2_zero_r <= (u1_max_r == '0);
  end

  // Scale all three to bit length 30
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u3_s_r[i] <= 32'(scale_to30(64'(u2_v_r[i]), {1'b0, u2_len_r}));
    end
    u3_zero_r <= u2_zero_r;
  end

  // Square the components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full_c[i] = u3_s_r[i] * u3_s_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u4_sq_r[i] <= sq_full_c[i][60:0];
    end
    u4_s_r    <= u3_s_r;
    u4_zero_r <= u3_zero_r;
  end

  // Sum the squares; keep the root nonzero for a zero vector
  assign sum_c = 62'(u4_sq_r[0]) + 62'(u4_sq_r[1]) + 62'(u4_sq_r[2]);

  always_ff @(posedge clk) begin
    sq_r[0].rem  <= u4_zero_r ? 63'd1 : 63'(sum_c);
    sq_r[0].res  <= '0;
    for (int i = 0; i < 3; i++) begin
      sq_r[0].s[i] <= u4_s_r[i];
    end
    sq_r[0].zero <= u4_zero_r;
  end

  // Integer square root, two radicand bits a stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [62:0] BITV = 63'(1) << (62 - 2 * j);
    logic [63:0] trial;
    sq_t         sq_nxt;

    assign trial = 64'(sq_r[j].res) + 64'(BITV);

    always_comb begin
      sq_nxt = sq_r[j];
      if ({1'b0, sq_r[j].rem} >= trial) begin
        sq_nxt.rem = sq_r[j].rem - trial[62:0];
        sq_nxt.res = (sq_r[j].res >> 1) + BITV;
      end else begin
        sq_nxt.res = sq_r[j].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      sq_r[j+1] <= sq_nxt;
    end
  end

  // Form the rounded dividends
  always_comb begin
    logic signed [31:0] s;
    logic [30:0]        m;
    dv0_c.n    = sq_r[SQRT_STEPS].res[31:0];
    dv0_c.zero = sq_r[SQRT_STEPS].zero;
    dv0_c.q    = '0;
    for (int i = 0; i < 3; i++) begin
      s            = sq_r[SQRT_STEPS].s[i];
      m            = s[31] ? 31'(-s) : 31'(s);
      dv0_c.neg[i] = s[31];
      dv0_c.rem[i] = (61'(m) << 28) + 61'(dv0_c.n >> 1);
    end
  end

  // Restoring division, one quotient bit a stage, three lanes
  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    localparam int B = QUOT_BITS - 1 - j;
    dv_t         d_in;
    dv_t         dv_nxt;
    logic [60:0] dsr;

    if (j == 0) begin : g_first
      assign d_in = dv0_c;
    end else begin : g_next
      assign d_in = dv_r[j];
    end

    assign dsr = 61'(d_in.n) << B;

    always_comb begin
      dv_nxt = d_in;
      for (int i = 0; i < 3; i++) begin
        if (d_in.rem[i] >= dsr) begin
          dv_nxt.rem[i]  = d_in.rem[i] - dsr;
          dv_nxt.q[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      dv_r[j+1] <= dv_nxt;
    end
  end

  // Apply signs
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      out_u_r[i] <= dv_r[QUOT_BITS].neg[i] ? -unit_t'({1'b0, dv_r[QUOT_BITS].q[i]})
                                            : unit_t'({1'b0, dv_r[QUOT_BITS].q[i]});
    end
    out_ok_r <= !dv_r[QUOT_BITS].zero;
  end

  assign out_valid = out_vld_r;
  assign out_ok    = out_ok_r;
  assign out_u     = out_u_r;

endmodule

`default_nettype wire

### rtl/core/polarization_azimuth_angle.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Transaction
// input     start, busy, in_*                       start high and busy low at a clock edge
// result    out_valid, out_big_phi, out_degenerate  out_valid high for one cycle
//
// One transaction can enter every cycle while busy is low; each result passes
// through the square root and divider stages of the unit vectors, then the
// product stages and the vectoring CORDIC, one step a stage.
// Synchronous active-low reset clears all valid bits; busy is high only in reset.
// The receiver cannot stall, so the pipeline always advances.
module polarization_azimuth_angle #(
  parameter int MOMENTUM_WIDTH = 24,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  paz_pkg::pol_t                    in_pol_angle,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_beam_px,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_beam_py,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_beam_pz,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_recoil_px,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_recoil_py,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_recoil_pz,
  output logic                             out_valid,
  output paz_pkg::phi_t                    out_big_phi,
  output logic                             out_degenerate
);
  import paz_pkg::*;

  localparam int MW      = MOMENTUM_WIDTH;
  localparam int CS      = CORDIC_STEPS;
  localparam int ANG_LAT = 9 + CS;
  localparam int DLY     = UNIT_LAT - ANG_LAT;
  localparam int L_TOTAL = UNIT_LAT + 11 + CS;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic [35:0] rem;
    logic [4:0]  k;
  } kq_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         k;
  } rc_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               deg;
    logic               zero;
  } vc_t;

  function automatic logic signed [63:0] round_q28(input logic signed [63:0] v);
    return (v + 64'sd134217728) >>> 28;
  endfunction

  logic in_acc;

  // Valid bits
  logic [DLY-1:0] dly_vld_r;
  logic           a1_vld_r;
  logic [5:0]     kq_vld_r;
  logic [CS:0]    rc_vld_r;
  logic           q_vld_r;
  logic [6:1]     m_vld_r;
  logic [3:1]     t_vld_r;
  logic [CS:0]    vc_vld_r;
  logic           out_valid_r;

  // Unit vector path
  logic signed [MW-1:0] beam_v [3];
  logic signed [MW-1:0] recoil_v [3];
  logic                 b_vld, b_ok, r_vld, r_ok;
  unit_t                b_u [3];
  unit_t                r_u [3];

  // Angle path
  pol_t               dly_pol_r [DLY];
  logic signed [49:0] a1_prod_r;
  logic signed [49:0] a_c;
  logic signed [49:0] t_c;
  kq_t                kq_r [6];
  rc_t                rc_r [CS+1];
  logic signed [31:0] q_ex_r, q_ey_r;

  // Product stages
  logic signed [63:0] m1_prod_r [6];
  unit_t              m1_b_r [3];
  logic signed [31:0] m1_ex_r, m1_ey_r;
  logic               m1_ok_r;
  logic signed [31:0] m2_w_r [3];
  unit_t              m2_b_r [3];
  logic signed [31:0] m2_ex_r, m2_ey_r;
  logic               m2_ok_r;
  logic signed [63:0] m3_prod_r [6];
  unit_t              m3_b_r [3];
  logic               m3_deg_r;
  logic signed [63:0] m4_yv_r;
  logic signed [33:0] m4_p_r [3];
  unit_t              m4_b_r [3];
  logic               m4_deg_r;
  logic signed [63:0] m5_bp_r [3];
  logic signed [63:0] m5_yv_r;
  logic               m5_deg_r;
  logic signed [63:0] m6_xv_r, m6_yv_r;
  logic               m6_deg_r;

  // Angle recovery
  logic [63:0]        mx_c, my_c;
  logic [63:0]        t1_m_r;
  logic signed [63:0] t1_xv_r, t1_yv_r;
  logic               t1_deg_r;
  logic [6:0]         t2_len_r;
  logic               t2_zero_r, t2_deg_r;
  logic signed [63:0] t2_xv_r, t2_yv_r;
  logic signed [33:0] t3_x_r, t3_y_r;
  logic               t3_zero_r, t3_deg_r;
  vc_t                vc_r [CS+1];
  logic signed [33:0] zr_c;
  phi_t               phi_c;
  phi_t               out_big_phi_r;
  logic               out_degenerate_r;

  assign busy   = !rst_n;
  assign in_acc = start && !busy;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r   <= '0;
      a1_vld_r    <= 1'b0;
      kq_vld_r    <= '0;
      rc_vld_r    <= '0;
      q_vld_r     <= 1'b0;
      m_vld_r     <= '0;
      t_vld_r     <= '0;
      vc_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dly_vld_r   <= {dly_vld_r[DLY-2:0], in_acc};
      a1_vld_r    <= dly_vld_r[DLY-1];
      kq_vld_r    <= {kq_vld_r[4:0], a1_vld_r};
      rc_vld_r    <= {rc_vld_r[CS-1:0], kq_vld_r[5]};
      q_vld_r     <= rc_vld_r[CS];
      m_vld_r     <= {m_vld_r[5:1], b_vld};
      t_vld_r     <= {t_vld_r[2:1], m_vld_r[6]};
      vc_vld_r    <= {vc_vld_r[CS-1:0], t_vld_r[3]};
      out_valid_r <= vc_vld_r[CS];
    end
  end

  // Normalize beam and recoil momenta
  assign beam_v[0]   = in_beam_px;
  assign beam_v[1]   = in_beam_py;
  assign beam_v[2]   = in_beam_pz;
  assign recoil_v[0] = in_recoil_px;
  assign recoil_v[1] = in_recoil_py;
  assign recoil_v[2] = in_recoil_pz;

  paz_unit3 #(.MOMENTUM_WIDTH(MW)) u_beam (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_acc),
    .in_v     (beam_v),
    .out_valid(b_vld),
    .out_ok   (b_ok),
    .out_u    (b_u)
  );

  paz_unit3 #(.MOMENTUM_WIDTH(MW)) u_recoil (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_acc),
    .in_v     (recoil_v),
    .out_valid(r_vld),
    .out_ok   (r_ok),
    .out_u    (r_u)
  );

  // Delay the angle so sin and cos meet the unit vectors
  always_ff @(posedge clk) begin
    dly_pol_r[0] <= in_pol_angle;
    for (int k = 1; k < DLY; k++) begin
      dly_pol_r[k] <= dly_pol_r[k-1];
    end
  end

  // Convert degrees to radians
  always_ff @(posedge clk) begin
    a1_prod_r <= dly_pol_r[DLY-1] * DEG_TO_RAD_Q36;
  end

  assign a_c = (a1_prod_r + 50'sd8192) >>> 14;
  assign t_c = a_c + $signed({14'b0, ANGLE_OFFSET});

  always_ff @(posedge clk) begin
    kq_r[0].rem <= t_c[35:0];
    kq_r[0].k   <= '0;
  end

  // Find the quadrant count, one bit a stage
  for (genvar j = 0; j < 5; j++) begin : g_kq
    localparam logic [35:0] DIV = 36'(HALF_PI_Q30) << (4 - j);
    kq_t kq_nxt;

    always_comb begin
      kq_nxt = kq_r[j];
      if (kq_r[j].rem >= DIV) begin
        kq_nxt.rem      = kq_r[j].rem - DIV;
        kq_nxt.k[4 - j] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      kq_r[j+1] <= kq_nxt;
    end
  end

  // Center the remainder on zero and seed the rotation
  always_ff @(posedge clk) begin
    rc_r[0].x <= GAIN_Q28;
    rc_r[0].y <= '0;
    rc_r[0].z <= $signed(34'(kq_r[5].rem)) - QUARTER_PI_S;
    rc_r[0].k <= kq_r[5].k[1:0];
  end

  // Rotation CORDIC, one step a stage
  for (genvar i = 0; i < CS; i++) begin : g_rot
    localparam logic signed [33:0] AT = 34'(ATAN_Q30[i]);
    logic signed [33:0] xi, yi, zi;
    rc_t                rc_nxt;

    assign xi = rc_r[i].x;
    assign yi = rc_r[i].y;
    assign zi = rc_r[i].z;

    always_comb begin
      rc_nxt = rc_r[i];
      if (zi >= 0) begin
        rc_nxt.x = xi - (yi >>> i);
        rc_nxt.y = yi + (xi >>> i);
        rc_nxt.z = zi - AT;
      end else begin
        rc_nxt.x = xi + (yi >>> i);
        rc_nxt.y = yi - (xi >>> i);
        rc_nxt.z = zi + AT;
      end
    end

    always_ff @(posedge clk) begin
      rc_r[i+1] <= rc_nxt;
    end
  end

  // Map the quadrant onto cos and sin
  always_ff @(posedge clk) begin
    case (rc_r[CS].k)
      QUAD_0: begin
        q_ex_r <= 32'(rc_r[CS].x);
        q_ey_r <= 32'(rc_r[CS].y);
      end
      QUAD_1: begin
        q_ex_r <= 32'(-rc_r[CS].y);
        q_ey_r <= 32'(rc_r[CS].x);
      end
      QUAD_2: begin
        q_ex_r <= 32'(-rc_r[CS].x);
        q_ey_r <= 32'(-rc_r[CS].y);
      end
      default: begin
        q_ex_r <= 32'(rc_r[CS].y);
        q_ey_r <= 32'(-rc_r[CS].x);
      end
    endcase
  end

  // Cross product terms of recoil and beam
  always_ff @(posedge clk) begin
    m1_prod_r[0] <= r_u[1] * b_u[2];
    m1_prod_r[1] <= r_u[2] * b_u[1];
    m1_prod_r[2] <= r_u[2] * b_u[0];
    m1_prod_r[3] <= r_u[0] * b_u[2];
    m1_prod_r[4] <= r_u[0] * b_u[1];
    m1_prod_r[5] <= r_u[1] * b_u[0];
    m1_b_r       <= b_u;
    m1_ex_r      <= q_ex_r;
    m1_ey_r      <= q_ey_r;
    m1_ok_r      <= b_ok && r_ok;
  end

  // Round the plane normal to Q28
  always_ff @(posedge clk) begin
    m2_w_r[0] <= 32'(round_q28(m1_prod_r[0] - m1_prod_r[1]));
    m2_w_r[1] <= 32'(round_q28(m1_prod_r[2] - m1_prod_r[3]));
    m2_w_r[2] <= 32'(round_q28(m1_prod_r[4] - m1_prod_r[5]));
    m2_b_r    <= m1_b_r;
    m2_ex_r   <= m1_ex_r;
    m2_ey_r   <= m1_ey_r;
    m2_ok_r   <= m1_ok_r;
  end

  // Products of the normal with the polarization vector
  always_ff @(posedge clk) begin
    m3_prod_r[0] <= m2_w_r[0] * m2_ex_r;
    m3_prod_r[1] <= m2_w_r[1] * m2_ey_r;
    m3_prod_r[2] <= m2_ey_r * m2_w_r[2];
    m3_prod_r[3] <= m2_ex_r * m2_w_r[2];
    m3_prod_r[4] <= m2_ex_r * m2_w_r[1];
    m3_prod_r[5] <= m2_ey_r * m2_w_r[0];
    m3_b_r       <= m2_b_r;
    m3_deg_r     <= !m2_ok_r || (m2_w_r[0] == '0 && m2_w_r[1] == '0 && m2_w_r[2] == '0);
  end

  // Form the sine term and round eps x w to Q28
  always_ff @(posedge clk) begin
    m4_yv_r   <= m3_prod_r[0] + m3_prod_r[1];
    m4_p_r[0] <= 34'(round_q28(m3_prod_r[2]));
    m4_p_r[1] <= 34'(round_q28(-m3_prod_r[3]));
    m4_p_r[2] <= 34'(round_q28(m3_prod_r[4] - m3_prod_r[5]));
    m4_b_r    <= m3_b_r;
    m4_deg_r  <= m3_deg_r;
  end

  // Project onto the beam
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m5_bp_r[i] <= m4_b_r[i] * m4_p_r[i];
    end
    m5_yv_r  <= m4_yv_r;
    m5_deg_r <= m4_deg_r;
  end

  always_ff @(posedge clk) begin
    m6_xv_r  <= m5_bp_r[0] + m5_bp_r[1] + m5_bp_r[2];
    m6_yv_r  <= m5_yv_r;
    m6_deg_r <= m5_deg_r;
  end

  // Take the larger magnitude of the pair
  assign mx_c = m6_xv_r[63] ? 64'(-m6_xv_r) : 64'(m6_xv_r);
  assign my_c = m6_yv_r[63] ? 64'(-m6_yv_r) : 64'(m6_yv_r);

  always_ff @(posedge clk) begin
    t1_m_r   <= (mx_c > my_c) ? mx_c : my_c;
    t1_xv_r  <= m6_xv_r;
    t1_yv_r  <= m6_yv_r;
    t1_deg_r <= m6_deg_r;
  end

  always_ff @(posedge clk) begin
    t2_len_r  <= bit_len(t1_m_r);
    t2_zero_r <= (t1_m_r == '0);
    t2_xv_r   <= t1_xv_r;
    t2_yv_r   <= t1_yv_r;
    t2_deg_r  <= t1_deg_r;
  end

  // Normalize the pair to bit length 30
  always_ff @(posedge clk) begin
    t3_x_r    <= 34'(scale_to30(t2_xv_r, t2_len_r));
    t3_y_r    <= 34'(scale_to30(t2_yv_r, t2_len_r));
    t3_zero_r <= t2_zero_r;
    t3_deg_r  <= t2_deg_r;
  end

  // Turn a left half-plane pair by a quarter turn
  always_ff @(posedge clk) begin
    vc_r[0].deg  <= t3_deg_r;
    vc_r[0].zero <= t3_zero_r;
    if (t3_x_r < 0) begin
      if (t3_y_r >= 0) begin
        vc_r[0].x <= t3_y_r;
        vc_r[0].y <= -t3_x_r;
        vc_r[0].z <= HALF_PI_S;
      end else begin
        vc_r[0].x <= -t3_y_r;
        vc_r[0].y <= t3_x_r;
        vc_r[0].z <= -HALF_PI_S;
      end
    end else begin
      vc_r[0].x <= t3_x_r;
      vc_r[0].y <= t3_y_r;
      vc_r[0].z <= '0;
    end
  end

  // Vectoring CORDIC, one step a stage
  for (genvar i = 0; i < CS; i++) begin : g_vec
    localparam logic signed [33:0] AT = 34'(ATAN_Q30[i]);
    logic signed [33:0] xi, yi, zi;
    vc_t                vc_nxt;

    assign xi = vc_r[i].x;
    assign yi = vc_r[i].y;
    assign zi = vc_r[i].z;

    always_comb begin
      vc_nxt = vc_r[i];
      if (yi >= 0) begin
        vc_nxt.x = xi + (yi >>> i);
        vc_nxt.y = yi - (xi >>> i);
        vc_nxt.z = zi + AT;
      end else begin
        vc_nxt.x = xi - (yi >>> i);
        vc_nxt.y = yi + (xi >>> i);
        vc_nxt.z = zi - AT;
      end
    end

    always_ff @(posedge clk) begin
      vc_r[i+1] <= vc_nxt;
    end
  end

  // Round to Q13 and clamp
  assign zr_c = (vc_r[CS].z + 34'sd65536) >>> 17;

  always_comb begin
    if (vc_r[CS].deg || vc_r[CS].zero) begin
      phi_c = '0;
    end else if (zr_c > 34'(PHI_LIMIT)) begin
      phi_c = PHI_LIMIT;
    end else if (zr_c < -34'(PHI_LIMIT)) begin
      phi_c = -PHI_LIMIT;
    end else begin
      phi_c = 16'(zr_c);
    end
  end

  always_ff @(posedge clk) begin
    out_big_phi_r    <= phi_c;
    out_degenerate_r <= vc_r[CS].deg;
  end

  assign out_valid      = out_valid_r;
  assign out_big_phi    = out_big_phi_r;
  assign out_degenerate = out_degenerate_r;

`ifndef NO_ASSERTIONS
  // Unit vectors and sin/cos meet in the same cycle
  a_join: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld == r_vld) && (b_vld == q_vld_r))
    else $error("angle and unit vector paths out of step");

  // Every result comes from a transaction the fixed latency earlier
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(in_acc, L_TOTAL))
    else $error("result without matching input transaction");

  // A degenerate result carries a zero angle
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_degenerate_r) |-> (out_big_phi_r == '0))
    else $error("degenerate result with nonzero angle");

  // The angle stays inside its clamp
  a_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_big_phi_r <= PHI_LIMIT && out_big_phi_r >= -PHI_LIMIT))
    else $error("angle outside clamp range");
`endif

endmodule

`default_nettype wire

### tb/paz_checker.sv
`timescale 1ns / 1ps

module paz_checker #(
  parameter int MOMENTUM_WIDTH = 24,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  paz_pkg::pol_t                    in_pol_angle,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_beam_px,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_beam_py,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_beam_pz,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_recoil_px,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_recoil_py,
  input  logic signed [MOMENTUM_WIDTH-1:0] in_recoil_pz,
  input  logic                             out_valid,
  input  paz_pkg::phi_t                    out_big_phi,
  input  logic                             out_degenerate,
  output int                               fail_count,
  output int                               pending
);
  import paz_pkg::*;

  typedef struct packed {
    phi_t phi;
    logic degen;
  } angle_t;

  angle_t angle_q[$];
  int steps;

  assign pending = angle_q.size();
  initial fail_count = 0;
  initial steps = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  // Floor shift toward -inf on signed 64-bit
  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint round_shr(longint x, int s);
    if (s == 0) return x;
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int bits_of(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic longint unsigned abs_of(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint norm30(longint v, int len);
    if (len > 30) return round_shr(v, len - 30);
    return v <<< (30 - len);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Unit vector in Q28; returns 0 for a zero-length vector
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m, sq, n, q;
    longint s[3];
    int len;
    m = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) if (abs_of(v[i]) > m) m = abs_of(v[i]);
    if (m == 0) return 0;
    len = bits_of(m);
    for (int i = 0; i < 3; i++) begin
      s[i] = norm30(v[i], len);
      sq += longint'(s[i] * s[i]);
    end
    n = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((abs_of(s[i]) << 28) + n / 2) / n;
      u[i] = (s[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void pol_sincos(longint a, output longint c, output longint s);
    longint t, k, z, x, y, dx, dy, hp;
    hp = longint'(HALF_PI_Q30);
    t = a + 16 * hp + hp / 2;
    k = t / hp;
    z = t - k * hp - hp / 2;
    x = longint'(GAIN_Q28);
    y = 0;
    for (int i = 0; i < steps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    case (k & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint vec_atan2(longint yv, longint xv);
    longint unsigned m;
    longint x, y, t, z, dx, dy, hp;
    int len;
    hp = longint'(HALF_PI_Q30);
    m = (abs_of(xv) > abs_of(yv)) ? abs_of(xv) : abs_of(yv);
    if (m == 0) return 0;
    len = bits_of(m);
    x = norm30(xv, len);
    y = norm30(yv, len);
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = hp;
      end else begin
        x = -y; y = t; z = -hp;
      end
    end
    for (int i = 0; i < steps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end
    end
    z = round_shr(z, 17);
    if (z > PHI_LIMIT) z = PHI_LIMIT;
    if (z < -PHI_LIMIT) z = -PHI_LIMIT;
    return z;
  endfunction

  function automatic angle_t azimuth(longint pol, longint bv[3], longint rv[3]);
    longint b[3], r[3], w[3], p[3];
    longint a, ex, ey, yv, xv;
    angle_t res;
    res.phi = '0;
    res.degen = 1'b1;
    if (!unit_vec(bv, b) || !unit_vec(rv, r)) return res;
    w[0] = round_shr(r[1] * b[2] - r[2] * b[1], 28);
    w[1] = round_shr(r[2] * b[0] - r[0] * b[2], 28);
    w[2] = round_shr(r[0] * b[1] - r[1] * b[0], 28);
    if (w[0] == 0 && w[1] == 0 && w[2] == 0) return res;
    a = round_shr(pol * longint'(DEG_TO_RAD_Q36), 14);
    pol_sincos(a, ex, ey);
    yv = w[0] * ex + w[1] * ey;
    p[0] = round_shr(ey * w[2], 28);
    p[1] = round_shr(-ex * w[2], 28);
    p[2] = round_shr(ex * w[1] - ey * w[0], 28);
    xv = b[0] * p[0] + b[1] * p[1] + b[2] * p[2];
    res.phi = phi_t'(vec_atan2(yv, xv));
    res.degen = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Predict on accepted input, compare on each result
  always @(posedge clk) begin
    longint bv[3], rv[3];
    angle_t exp_a;
    if (rst_n) begin
      if (start && !busy) begin
        bv = '{longint'(in_beam_px), longint'(in_beam_py), longint'(in_beam_pz)};
        rv = '{longint'(in_recoil_px), longint'(in_recoil_py), longint'(in_recoil_pz)};
        angle_q.push_back(azimuth(longint'(in_pol_angle), bv, rv));
      end
      if (out_valid) begin
        if (angle_q.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          exp_a = angle_q.pop_front();
          if (out_big_phi !== exp_a.phi)
            report_mismatch($sformatf("big_phi got %0d want %0d", out_big_phi, exp_a.phi));
          if (out_degenerate !== exp_a.degen)
            report_mismatch($sformatf("degenerate got %0b want %0b",
                                      out_degenerate, exp_a.degen));
        end
      end
    end
  end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import paz_pkg::*;

  localparam int MW = 24;
  localparam int LATENCY = UNIT_LAT + 16 + 11;
  localparam int WATCHDOG = 20000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk, rst_n, start, busy;
  pol_t in_pol_angle;
  logic signed [MW-1:0] in_beam_px, in_beam_py, in_beam_pz;
  logic signed [MW-1:0] in_recoil_px, in_recoil_py, in_recoil_pz;
  logic out_valid, out_degenerate;
  phi_t out_big_phi;
  int fail_count, pending, idle_cycles;

  polarization_azimuth_angle uut (.*);
  paz_checker chk (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Watchdog: count cycles with no accepted transaction and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [MW-1:0] rand_mom();
    case ($urandom_range(0, 5))
      0: return MW'($urandom_range(0, 40) - 20);
      1: return $urandom_range(0, 1) ? {1'b0, {(MW-1){1'b1}}} : {1'b1, {(MW-1){1'b0}}};
      2: return MW'($urandom_range(0, 2000000) - 1000000);
      default: return MW'($urandom);
    endcase
  endfunction

  // Drive one event and hold until it is taken
  task automatic send_event(pol_t pol, logic signed [MW-1:0] bx, by, bz, rx, ry, rz);
    start <= 1'b1;
    in_pol_angle <= pol;
    in_beam_px <= bx; in_beam_py <= by; in_beam_pz <= bz;
    in_recoil_px <= rx; in_recoil_py <= ry; in_recoil_pz <= rz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  localparam logic signed [MW-1:0] ONE = 24'sd65536;
  localparam logic signed [MW-1:0] MAXM = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] MINM = {1'b1, {(MW-1){1'b0}}};

  initial begin
    int burst, wait_n;
    pol_t pol;
    logic signed [MW-1:0] bx, by, bz;
    rst_n = 1'b0;
    start = 1'b0;
    in_pol_angle = '0;
    {in_beam_px, in_beam_py, in_beam_pz} = '0;
    {in_recoil_px, in_recoil_py, in_recoil_pz} = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: angle extremes, zero vectors, parallel, beam along eps
    send_event(18'sd92160, 0, 0, ONE, ONE, 0, 0);
    send_event(-18'sd92160, 0, 0, ONE, 0, ONE, ONE);
    send_event(18'sd131071, 0, 0, ONE, ONE, ONE, 0);
    send_event(-18'sd131072, 0, 0, ONE, ONE, -ONE, ONE);
    send_event(0, 0, 0, 0, ONE, 0, 0);
    send_event(0, 0, 0, ONE, 0, 0, 0);
    send_event(0, 0, 0, 0, 0, 0, 0);
    send_event(18'sd2560, 0, 0, ONE, 0, 0, MW'(5 * ONE));
    send_event(18'sd2560, ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_event(0, ONE, 0, 0, 0, ONE, 0);
    send_event(18'sd23040, 0, ONE, 0, ONE, 0, 0);
    send_event(18'sd11520, MAXM, MAXM, MAXM, MINM, MAXM, MINM);
    send_event(-18'sd11520, MINM, MINM, MINM, MAXM, MINM, 0);
    send_event(18'sd46080, 1, 0, 0, 0, -1, 0);
    send_event(18'sd256, MAXM, 1, -1, 1, MAXM, 1);
    send_event(18'sd5000, 0, 0, MINM, 3, 0, MINM);

    // Random: bursts, half physical-looking momenta, half noise
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst && n < RANDOM_ITEMS; j++, n++) begin
        pol = ($urandom_range(0, 4) == 0) ? pol_t'($urandom)
            : pol_t'($urandom_range(0, 184320)) - 18'sd92160;
        bx = rand_mom(); by = rand_mom(); bz = rand_mom();
        if ($urandom_range(0, 9) == 0)
          send_event(pol, bx, by, bz, bx <<< 1, by <<< 1, bz <<< 1);
        else
          send_event(pol, bx, by, bz, rand_mom(), rand_mom(), rand_mom());
      end
      pause_sender();
    end
    start <= 1'b0;

    // Drain
    wait_n = 0;
    while (pending != 0 && wait_n < 4 * LATENCY) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
